// ===== rtl/rmst_pkg.sv =====
// Shared types and constants for the range maximum segment tree.
package rmst_pkg;

  // Tree geometry: leaves sit at node MaxEntries + index
  localparam int unsigned IdxW       = 10;
  localparam int unsigned MaxEntries = 1 << IdxW;
  localparam int unsigned NodeAw     = IdxW + 1;
  localparam int unsigned NodeDepth  = 1 << NodeAw;
  localparam int unsigned SizeW      = IdxW + 1;
  localparam int unsigned BoundW     = NodeAw + 1;
  localparam int unsigned DataW      = 32;

  // Stored keys have the sign bit inverted so that an unsigned compare orders them
  localparam logic [DataW-1:0] SignFlip = {1'b1, {(DataW-1){1'b0}}};
  localparam logic [DataW-1:0] KeyMin   = '0;
  localparam logic [SizeW-1:0] UsedSizeReset = SizeW'(MaxEntries);

  // Operation codes
  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef enum logic [1:0] {
    StatOk       = 2'd0,
    StatBadRange = 2'd1,
    StatBadIndex = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StLeaf,
    StUpd,
    StQry,
    StDone
  } state_e;

  // Node memory access for one cycle
  typedef struct packed {
    logic              we;
    logic [NodeAw-1:0] waddr;
    logic [DataW-1:0]  wdata;
    logic [NodeAw-1:0] raddr0;
    logic [NodeAw-1:0] raddr1;
  } ram_req_t;

  // Finished result handed to the output register
  typedef struct packed {
    logic [DataW-1:0] max_value;
    status_e          status;
  } result_t;

endpackage

// ===== rtl/rmst_node_ram.sv =====
// Node store: one write port, two read ports, registered read data.
module rmst_node_ram (
  input  logic                        clk_i,
  input  rmst_pkg::ram_req_t          req_i,
  output logic [rmst_pkg::DataW-1:0]  rdata0_o,
  output logic [rmst_pkg::DataW-1:0]  rdata1_o
);

  logic [rmst_pkg::DataW-1:0] mem_q [rmst_pkg::NodeDepth];
  logic [rmst_pkg::DataW-1:0] rdata0_q;
  logic [rmst_pkg::DataW-1:0] rdata1_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read ports, registered read data
  always_ff @(posedge clk_i) begin
    rdata0_q <= mem_q[req_i.raddr0];
    rdata1_q <= mem_q[req_i.raddr1];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

// ===== rtl/rmst_ctrl.sv =====
// Sequencer: clearing sweep, leaf-to-root update and bottom-up range query.
module rmst_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         operation_i,
  input  logic [rmst_pkg::IdxW-1:0]    position_i,
  input  logic [rmst_pkg::IdxW-1:0]    last_position_i,
  input  logic signed [rmst_pkg::DataW-1:0] value_i,
  input  logic [rmst_pkg::SizeW-1:0]   used_size_i,
  input  logic                         out_free_i,
  output logic                         res_load_o,
  output rmst_pkg::result_t            result_o,
  output rmst_pkg::ram_req_t           ram_req_o,
  input  logic [rmst_pkg::DataW-1:0]   rdata0_i,
  input  logic [rmst_pkg::DataW-1:0]   rdata1_i
);

  rmst_pkg::state_e                state_q, state_d;
  logic [rmst_pkg::NodeAw-1:0]     clr_q, clr_d;
  logic [rmst_pkg::NodeAw-1:0]     cur_q, cur_d;
  logic [rmst_pkg::DataW-1:0]      val_q, val_d;
  logic [rmst_pkg::BoundW-1:0]     lo_q, lo_d;
  logic [rmst_pkg::BoundW-1:0]     hi_q, hi_d;
  logic                            f0_q, f0_d;
  logic                            f1_q, f1_d;
  logic [rmst_pkg::DataW-1:0]      best0_q, best0_d;
  logic [rmst_pkg::DataW-1:0]      best1_q, best1_d;
  logic                            is_query_q, is_query_d;
  rmst_pkg::status_e               status_q, status_d;

  logic [rmst_pkg::SizeW-1:0]      eff_size;
  logic [rmst_pkg::SizeW-1:0]      pos_ext;
  logic [rmst_pkg::SizeW-1:0]      last_ext;
  logic [rmst_pkg::NodeAw-1:0]     parent;
  logic [rmst_pkg::DataW-1:0]      up_max;
  logic [rmst_pkg::DataW-1:0]      best_all;

  // Clamp the configured size to the tree capacity
  assign eff_size = (used_size_i > rmst_pkg::SizeW'(rmst_pkg::MaxEntries))
                    ? rmst_pkg::SizeW'(rmst_pkg::MaxEntries) : used_size_i;
  assign pos_ext  = {1'b0, position_i};
  assign last_ext = {1'b0, last_position_i};

  assign parent   = cur_q >> 1;
  assign up_max   = (rdata0_i > val_q) ? rdata0_i : val_q;
  assign best_all = (best1_q > best0_q) ? best1_q : best0_q;

  assign in_ready_o          = (state_q == rmst_pkg::StIdle);
  assign result_o.max_value  = is_query_q ? (best_all ^ rmst_pkg::SignFlip) : '0;
  assign result_o.status     = status_q;

  // Next state, memory requests and datapath
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    cur_d      = cur_q;
    val_d      = val_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    f0_d       = f0_q;
    f1_d       = f1_q;
    best0_d    = best0_q;
    best1_d    = best1_q;
    is_query_d = is_query_q;
    status_d   = status_q;
    res_load_o = 1'b0;
    ram_req_o  = '0;

    unique case (state_q)
      // Sweep every node to the minimum key
      rmst_pkg::StClear: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = clr_q;
        ram_req_o.wdata = rmst_pkg::KeyMin;
        clr_d           = clr_q + 1'b1;
        if (clr_q == {rmst_pkg::NodeAw{1'b1}}) begin
          state_d = rmst_pkg::StIdle;
        end
      end

      // Take a request and check its bounds
      rmst_pkg::StIdle: begin
        if (in_valid_i) begin
          is_query_d = 1'b0;
          status_d   = rmst_pkg::StatOk;
          state_d    = rmst_pkg::StDone;
          if (operation_i == rmst_pkg::OpWrite) begin
            if (pos_ext < eff_size) begin
              cur_d   = {1'b1, position_i};
              val_d   = $unsigned(value_i) ^ rmst_pkg::SignFlip;
              state_d = rmst_pkg::StLeaf;
            end else begin
              status_d = rmst_pkg::StatBadIndex;
            end
          end else begin
            if ((pos_ext <= last_ext) && (last_ext < eff_size)) begin
              is_query_d = 1'b1;
              lo_d       = {2'b01, position_i};
              hi_d       = {2'b01, last_position_i} + 1'b1;
              f0_d       = 1'b0;
              f1_d       = 1'b0;
              best0_d    = rmst_pkg::KeyMin;
              best1_d    = rmst_pkg::KeyMin;
              state_d    = rmst_pkg::StQry;
            end else begin
              status_d = rmst_pkg::StatBadRange;
            end
          end
        end
      end

      // Write the leaf and fetch its sibling
      rmst_pkg::StLeaf: begin
        ram_req_o.we     = 1'b1;
        ram_req_o.waddr  = cur_q;
        ram_req_o.wdata  = val_q;
        ram_req_o.raddr0 = cur_q ^ rmst_pkg::NodeAw'(1);
        state_d          = rmst_pkg::StUpd;
      end

      // Write one ancestor a cycle and fetch the next sibling
      rmst_pkg::StUpd: begin
        ram_req_o.we     = 1'b1;
        ram_req_o.waddr  = parent;
        ram_req_o.wdata  = up_max;
        ram_req_o.raddr0 = parent ^ rmst_pkg::NodeAw'(1);
        cur_d            = parent;
        val_d            = up_max;
        if (parent == rmst_pkg::NodeAw'(1)) begin
          state_d = rmst_pkg::StDone;
        end
      end

      // Fold last cycle's reads, then issue the next level's border nodes
      rmst_pkg::StQry: begin
        if (f0_q && (rdata0_i > best0_q)) begin
          best0_d = rdata0_i;
        end
        if (f1_q && (rdata1_i > best1_q)) begin
          best1_d = rdata1_i;
        end
        if (lo_q < hi_q) begin
          ram_req_o.raddr0 = lo_q[rmst_pkg::NodeAw-1:0];
          ram_req_o.raddr1 = hi_q[rmst_pkg::NodeAw-1:0] - 1'b1;
          f0_d             = lo_q[0];
          f1_d             = hi_q[0];
          lo_d             = (lo_q + 1'b1) >> 1;
          hi_d             = hi_q >> 1;
        end else begin
          f0_d    = 1'b0;
          f1_d    = 1'b0;
          state_d = rmst_pkg::StDone;
        end
      end

      // Hand the result over once the output register is free
      rmst_pkg::StDone: begin
        if (out_free_i) begin
          res_load_o = 1'b1;
          state_d    = rmst_pkg::StIdle;
        end
      end

      default: begin
        state_d = rmst_pkg::StIdle;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rmst_pkg::StClear;
      clr_q   <= '0;
      f0_q    <= 1'b0;
      f1_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      f0_q    <= f0_d;
      f1_q    <= f1_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    val_q      <= val_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    best0_q    <= best0_d;
    best1_q    <= best1_d;
    is_query_q <= is_query_d;
    status_q   <= status_d;
  end

endmodule

// ===== rtl/range_max_segment_tree.sv =====
// Top level of the range maximum segment tree: size register, output register, assertions.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------------------
//  in       | in_valid_i / in_ready_o    | operation_i, position_i, last_position_i, value_i
//  out      | out_valid_o / out_ready_i  | max_value_o, status_o
//  cfg      | cfg_valid_i / cfg_ready_o  | cfg_used_size_i
//
// One request at a time. A write steps from acceptance through the leaf, ten ancestor
// levels and hand-over; a query works one tree level a cycle on two read ports; a rejected
// request goes straight to hand-over.
// After reset a clearing sweep writes every node; no request is taken
// meanwhile, while size writes are taken at any time.
// A result waits in the output register; a stalled output holds the sequencer at hand-over.
module range_max_segment_tree (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              operation_i,
  input  logic [rmst_pkg::IdxW-1:0]         position_i,
  input  logic [rmst_pkg::IdxW-1:0]         last_position_i,
  input  logic signed [rmst_pkg::DataW-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [rmst_pkg::DataW-1:0] max_value_o,
  output logic [1:0]                        status_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rmst_pkg::SizeW-1:0]        cfg_used_size_i
);

  logic [rmst_pkg::SizeW-1:0]     used_size_q;
  logic                           out_valid_q;
  rmst_pkg::result_t              out_q;
  logic                           out_free;
  logic                           res_load;
  rmst_pkg::result_t              result;
  rmst_pkg::ram_req_t             ram_req;
  logic [rmst_pkg::DataW-1:0]     rdata0;
  logic [rmst_pkg::DataW-1:0]     rdata1;

  assign cfg_ready_o = 1'b1;

  // Size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_size_q <= rmst_pkg::UsedSizeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      used_size_q <= cfg_used_size_i;
    end
  end

  // Output register: load on hand-over, drop once taken
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign max_value_o = $signed(out_q.max_value);
  assign status_o    = out_q.status;

  rmst_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .position_i      (position_i),
    .last_position_i (last_position_i),
    .value_i         (value_i),
    .used_size_i     (used_size_q),
    .out_free_i      (out_free),
    .res_load_o      (res_load),
    .result_o        (result),
    .ram_req_o       (ram_req),
    .rdata0_i        (rdata0),
    .rdata1_i        (rdata1)
  );

  rmst_node_ram u_node_ram (
    .clk_i    (clk_i),
    .req_i    (ram_req),
    .rdata0_o (rdata0),
    .rdata1_o (rdata1)
  );

  // A result is loaded only into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_load |-> out_free)
    else $error("result loaded over a pending one");

  // No new request while a result is being handed over
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(in_ready_o && res_load))
    else $error("request taken during hand-over");

  // Errors report a zero value; writes do as well, but only errors are checked here
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o && (status_o != rmst_pkg::StatOk) |-> (max_value_o == '0))
    else $error("non-zero value with an error status");

  // A hand-over shows up at the output in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_load |=> out_valid_o)
    else $error("loaded result not presented");

endmodule
